// ===== rtl/timer_bank_scheduler_unit_defines.svh =====
// Assertion macros shared by the timer bank scheduler RTL.
`ifndef TIMER_BANK_SCHEDULER_UNIT_DEFINES_SVH
`define TIMER_BANK_SCHEDULER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TBS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TBS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tbs_pkg.sv =====
// Types and constants of the timer bank scheduler.
`timescale 1ns / 1ps
package tbs_pkg;

  localparam int unsigned TICK_W      = 32;
  localparam int unsigned DELAY_W     = 31;
  localparam int unsigned ID_W        = 4;
  localparam int unsigned CMD_W       = 3;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned CNT_W       = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 3'd0,
    CMD_SCAN  = 3'd1,
    CMD_START = 3'd2,
    CMD_STOP  = 3'd3,
    CMD_QUERY = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    RS_STOPPED = 2'd0,
    RS_RUNNING = 2'd1,
    RS_TIMEOUT = 2'd2
  } run_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_DRAIN
  } fsm_e;

  localparam logic KIND_FIRED = 1'b0;
  localparam logic KIND_REPLY = 1'b1;

  typedef struct packed {
    logic            kind;
    logic [ID_W-1:0] fired_id;
    logic [1:0]      timer_state;
    logic            last;
  } evt_t;

endpackage

// ===== rtl/tbs_req_if.sv =====
// Command channel of the timer bank scheduler.
`timescale 1ns / 1ps
interface tbs_req_if;
  import tbs_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [ID_W-1:0]    timer_id;
  logic               mode;
  logic [DELAY_W-1:0] delay;

  modport source (output valid, cmd, timer_id, mode, delay, input ready);
  modport sink   (input valid, cmd, timer_id, mode, delay, output ready);
endinterface

// ===== rtl/tbs_rsp_if.sv =====
// Event and reply channel of the timer bank scheduler.
`timescale 1ns / 1ps
interface tbs_rsp_if;
  import tbs_pkg::*;

  logic            valid;
  logic            ready;
  logic            kind;
  logic [ID_W-1:0] fired_id;
  logic [1:0]      timer_state;
  logic            last;

  modport source (output valid, kind, fired_id, timer_state, last, input ready);
  modport sink   (input valid, kind, fired_id, timer_state, last, output ready);
endinterface

// ===== rtl/tbs_alu.sv =====
// Shared 32-bit add/subtract unit of the timer bank scheduler.
`timescale 1ns / 1ps
module tbs_alu (
  input  logic [tbs_pkg::TICK_W-1:0] a_i,
  input  logic [tbs_pkg::TICK_W-1:0] b_i,
  input  logic                       sub_i,
  output logic [tbs_pkg::TICK_W-1:0] sum_o
);
  import tbs_pkg::*;

  logic [TICK_W-1:0] b_inv;

  // Subtract as a plus inverted b plus one.
  assign b_inv = b_i ^ {TICK_W{sub_i}};
  assign sum_o = a_i + b_inv + TICK_W'(sub_i);

endmodule

// ===== rtl/timer_bank_scheduler_unit.sv =====
// Top level of the timer bank scheduler: sequencer, timer storage and result register.
// Commands: tick, start and stop leave ready high; a query holds ready low until its reply
//   moves from the held-result register to the result register, waiting while held off.
// Scan: one timer per cycle through the shared adder, held while a fired event waits for the
//   output; ready stays low through the scan, the drain state when a timer fired, and each wait.
// Reset: counter cleared, timers stopped and one-shot; match and period memories uncleared.
`timescale 1ns / 1ps
`include "timer_bank_scheduler_unit_defines.svh"
module timer_bank_scheduler_unit #(
  parameter int unsigned TIMER_COUNT = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tbs_req_if.sink    req_i,
  tbs_rsp_if.source  rsp_o
);
  import tbs_pkg::*;

  localparam int unsigned IDX_W    = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int unsigned CMP_W    = (IDX_W + 1 > ID_W) ? IDX_W + 1 : ID_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_COUNT - 1);

  // Sequencer and result registers.
  fsm_e              state_q, state_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [TICK_W-1:0] tick_q, tick_d;
  logic [CNT_W-1:0]  rep_cnt_q, rep_cnt_d;
  evt_t              pend_q, pend_d;
  logic              pend_valid_q, pend_valid_d;
  evt_t              out_q, out_d;
  logic              out_valid_q, out_valid_d;

  // Per-timer control state, cleared by reset.
  run_e                   run_state_q [TIMER_COUNT];
  logic [TIMER_COUNT-1:0] periodic_q;

  // Match tick and period storage.
  logic [TICK_W-1:0]  match_mem  [TIMER_COUNT];
  logic [DELAY_W-1:0] period_mem [TIMER_COUNT];
  logic [TICK_W-1:0]  match_rd_q;
  logic [DELAY_W-1:0] period_rd_q;

  logic               req_fire;
  logic               out_free;
  logic [CMP_W-1:0]   id_ext;
  logic               id_ok;
  logic [IDX_W-1:0]   id_idx;

  logic               rs_we;
  logic [IDX_W-1:0]   rs_waddr;
  run_e               rs_wdata;
  logic               per_we;
  logic               match_we;
  logic               period_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [IDX_W-1:0]   raddr;

  logic               alu_sub;
  logic [TICK_W-1:0]  alu_b;
  logic [TICK_W-1:0]  alu_sum;

  logic               reached;
  logic               report;
  logic               stall;
  run_e               cur_rs;
  evt_t               new_evt;

  logic               scan_fire;
  logic               at_scan_head;

  assign req_fire     = req_i.valid && req_i.ready;
  assign req_i.ready  = (state_q == FSM_IDLE);
  assign out_free     = !out_valid_q || rsp_o.ready;

  assign id_ext = CMP_W'(req_i.timer_id);
  assign id_ok  = (id_ext < CMP_W'(TIMER_COUNT));
  assign id_idx = IDX_W'(id_ext);

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.kind        = out_q.kind;
  assign rsp_o.fired_id    = out_q.fired_id;
  assign rsp_o.timer_state = out_q.timer_state;
  assign rsp_o.last        = out_q.last;

  // One adder serves arming (counter plus delay or period) and the wrap-safe match test.
  tbs_alu u_alu (
    .a_i   (tick_q),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .sum_o (alu_sum)
  );

  assign cur_rs  = run_state_q[idx_q];
  assign reached = !alu_sum[TICK_W-1];
  assign new_evt = '{kind: KIND_FIRED, fired_id: ID_W'(idx_q),
                     timer_state: RS_TIMEOUT, last: 1'b0};

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    tick_d       = tick_q;
    rep_cnt_d    = rep_cnt_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;

    rs_we     = 1'b0;
    rs_waddr  = idx_q;
    rs_wdata  = RS_STOPPED;
    per_we    = 1'b0;
    match_we  = 1'b0;
    period_we = 1'b0;
    mem_waddr = idx_q;
    raddr     = '0;
    alu_sub   = 1'b0;
    alu_b     = {1'b0, period_rd_q};
    report    = 1'b0;
    stall     = 1'b0;

    unique case (state_q)
      FSM_IDLE: begin
        // Keep entry zero on the read port so a scan starts with its data.
        if (req_fire) begin
          unique case (cmd_e'(req_i.cmd))
            CMD_TICK: begin
              tick_d = tick_q + TICK_W'(1);
            end
            CMD_SCAN: begin
              state_d   = FSM_SCAN;
              idx_d     = '0;
              rep_cnt_d = '0;
            end
            CMD_START: begin
              if (id_ok) begin
                alu_b     = {1'b0, req_i.delay};
                match_we  = 1'b1;
                period_we = 1'b1;
                mem_waddr = id_idx;
                rs_we     = 1'b1;
                rs_waddr  = id_idx;
                rs_wdata  = RS_RUNNING;
                per_we    = 1'b1;
              end
            end
            CMD_STOP: begin
              if (id_ok) begin
                rs_we    = 1'b1;
                rs_waddr = id_idx;
                rs_wdata = RS_STOPPED;
              end
            end
            CMD_QUERY: begin
              pend_d.kind        = KIND_REPLY;
              pend_d.fired_id    = req_i.timer_id;
              pend_d.timer_state = id_ok ? run_state_q[id_idx] : RS_STOPPED;
              pend_d.last        = 1'b1;
              pend_valid_d       = 1'b1;
              state_d            = FSM_DRAIN;
            end
            default: begin
            end
          endcase
        end
      end

      FSM_SCAN: begin
        unique case (cur_rs)
          RS_RUNNING: begin
            alu_sub = 1'b1;
            alu_b   = match_rd_q;
            if (reached) begin
              rs_we    = 1'b1;
              rs_wdata = RS_TIMEOUT;
              report   = (rep_cnt_q < CNT_W'(MAX_RESULTS));
            end
          end
          RS_TIMEOUT: begin
            rs_we = 1'b1;
            if (periodic_q[idx_q]) begin
              match_we = 1'b1;
              rs_wdata = RS_RUNNING;
            end else begin
              rs_wdata = RS_STOPPED;
            end
          end
          default: begin
          end
        endcase

        // A new event pushes the held one out; hold the whole entry if the output is busy.
        if (report && pend_valid_q) begin
          if (out_free) begin
            out_d       = pend_q;
            out_valid_d = 1'b1;
          end else begin
            stall = 1'b1;
          end
        end

        if (stall) begin
          rs_we    = 1'b0;
          match_we = 1'b0;
          raddr    = idx_q;
        end else begin
          if (report) begin
            pend_d       = new_evt;
            pend_valid_d = 1'b1;
            rep_cnt_d    = rep_cnt_q + CNT_W'(1);
          end
          if (idx_q == LAST_IDX) begin
            raddr   = idx_q;
            state_d = pend_valid_d ? FSM_DRAIN : FSM_IDLE;
          end else begin
            raddr = idx_q + IDX_W'(1);
            idx_d = idx_q + IDX_W'(1);
          end
        end
      end

      FSM_DRAIN: begin
        // Release the held result as the final one of this command.
        if (out_free) begin
          out_d        = pend_q;
          out_d.last   = 1'b1;
          out_valid_d  = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = FSM_IDLE;
        end
      end

      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= FSM_IDLE;
      idx_q        <= '0;
      tick_q       <= '0;
      rep_cnt_q    <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      tick_q       <= tick_d;
      rep_cnt_q    <= rep_cnt_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TIMER_COUNT; i++) begin
        run_state_q[i] <= RS_STOPPED;
      end
      periodic_q <= '0;
    end else begin
      if (rs_we) begin
        run_state_q[rs_waddr] <= rs_wdata;
      end
      if (per_we) begin
        periodic_q[rs_waddr] <= req_i.mode;
      end
    end
  end

  // Match and period memories: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (match_we) begin
      match_mem[mem_waddr] <= alu_sum;
    end
    if (period_we) begin
      period_mem[mem_waddr] <= req_i.delay;
    end
    match_rd_q  <= match_mem[raddr];
    period_rd_q <= period_mem[raddr];
  end

  assign scan_fire    = req_fire && (req_i.cmd == CMD_SCAN);
  assign at_scan_head = (state_q == FSM_SCAN) && (idx_q == '0);

  `TBS_ASSERT_IMP(a_drain_has_result, state_q == FSM_DRAIN, pend_valid_q, "drain with no result")
  `TBS_ASSERT_IMP(a_report_bound, 1'b1, rep_cnt_q <= CNT_W'(MAX_RESULTS), "event count over cap")
  `TBS_ASSERT_NXT(a_scan_start, scan_fire, at_scan_head, "scan did not start at timer zero")
  `TBS_ASSERT_IMP(a_stall_busy, stall, out_valid_q && !rsp_o.ready, "stall with output free")

endmodule

// ===== tb/sv/timer_bank_scheduler_unit_checker.sv =====
// Checker for the timer bank scheduler: watches both channels, predicts fired events and replies.
`timescale 1ns / 1ps
module timer_bank_scheduler_unit_checker #(
  parameter int unsigned TIMERS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tbs_req_if          req_i,
  tbs_rsp_if          rsp_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_count_o,
  output int unsigned fired_count_o,
  output int unsigned reply_count_o
);
  import tbs_pkg::*;

  localparam int unsigned PRINT_CAP = 50;

  // Shadow copy of the timer bank.
  logic [TICK_W-1:0]  tick_now;
  run_e               timer_run [TIMERS];
  logic               periodic  [TIMERS];
  logic [TICK_W-1:0]  match_at  [TIMERS];
  logic [DELAY_W-1:0] period_of [TIMERS];

  // Fired events and query replies still owed by the block, oldest first.
  evt_t pending_events [$];
  int unsigned results_seen;

  task automatic report_mismatch(input string what);
    if (mismatch_count_o < PRINT_CAP) $display("[%0t ns] MISMATCH %s", $time, what);
    mismatch_count_o++;
  endtask

  task automatic clear_bank();
    tick_now = '0;
    for (int i = 0; i < TIMERS; i++) begin
      timer_run[i] = RS_STOPPED;
      periodic[i]  = 1'b0;
      match_at[i]  = '0;
      period_of[i] = '0;
    end
    pending_events.delete();
  endtask

  // Apply one command to the shadow bank and queue the results it causes.
  task automatic advance_bank(input logic [CMD_W-1:0] op, input logic [ID_W-1:0] id,
                              input logic md, input logic [DELAY_W-1:0] dly);
    int unsigned       fired;
    logic [TICK_W-1:0] lag;
    evt_t              e;
    fired = 0;
    case (op)
      CMD_TICK: tick_now = tick_now + 1'b1;
      CMD_SCAN: begin
        for (int i = 0; i < TIMERS; i++) begin
          if (timer_run[i] == RS_RUNNING) begin
            // wrap-safe: reached when the signed difference is not negative
            lag = tick_now - match_at[i];
            if (!lag[TICK_W-1]) begin
              timer_run[i] = RS_TIMEOUT;
              if (fired < MAX_RESULTS) begin
                e.kind        = KIND_FIRED;
                e.fired_id    = ID_W'(i);
                e.timer_state = RS_TIMEOUT;
                e.last        = 1'b0;
                pending_events.push_back(e);
              end
              fired++;
            end
          end else if (timer_run[i] == RS_TIMEOUT) begin
            if (!periodic[i]) begin
              timer_run[i] = RS_STOPPED;
            end else begin
              match_at[i]  = tick_now + TICK_W'(period_of[i]);
              timer_run[i] = RS_RUNNING;
            end
          end
        end
        if (fired != 0) begin
          e      = pending_events.pop_back();
          e.last = 1'b1;
          pending_events.push_back(e);
        end
      end
      CMD_START: begin
        if (id < TIMERS) begin
          match_at[id]  = tick_now + TICK_W'(dly);
          period_of[id] = dly;
          timer_run[id] = RS_RUNNING;
          periodic[id]  = md;
        end
      end
      CMD_STOP: begin
        if (id < TIMERS) timer_run[id] = RS_STOPPED;
      end
      CMD_QUERY: begin
        e.kind        = KIND_REPLY;
        e.fired_id    = id;
        e.timer_state = (id < TIMERS) ? timer_run[id] : RS_STOPPED;
        e.last        = 1'b1;
        pending_events.push_back(e);
      end
      default: ;
    endcase
  endtask

  task automatic check_result();
    evt_t got;
    evt_t want;
    got = {rsp_i.kind, rsp_i.fired_id, rsp_i.timer_state, rsp_i.last};
    results_seen++;
    if (pending_events.size() == 0) begin
      report_mismatch($sformatf("result %0d unexpected: kind %0b id %0d state %0d last %0b",
                                results_seen, got.kind, got.fired_id, got.timer_state,
                                got.last));
    end else begin
      want = pending_events.pop_front();
      if (want.kind == KIND_FIRED) fired_count_o++;
      else reply_count_o++;
      if (got.kind !== want.kind)
        report_mismatch($sformatf("result %0d kind: got %0b, expected %0b",
                                  results_seen, got.kind, want.kind));
      if (got.fired_id !== want.fired_id)
        report_mismatch($sformatf("result %0d id: got %0d, expected %0d",
                                  results_seen, got.fired_id, want.fired_id));
      if (got.timer_state !== want.timer_state)
        report_mismatch($sformatf("result %0d state: got %0d, expected %0d",
                                  results_seen, got.timer_state, want.timer_state));
      if (got.last !== want.last)
        report_mismatch($sformatf("result %0d last: got %0b, expected %0b",
                                  results_seen, got.last, want.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_bank();
    end else begin
      if ($isunknown(rsp_i.valid))
        report_mismatch("result valid is unknown");
      // Results first: a command never answers in the cycle of its own transfer.
      if (rsp_i.valid === 1'b1 && rsp_i.ready === 1'b1) check_result();
      if (req_i.valid === 1'b1 && req_i.ready === 1'b1)
        advance_bank(req_i.cmd, req_i.timer_id, req_i.mode, req_i.delay);
    end
    pending_count_o = pending_events.size();
  end

endmodule

// ===== tb/sv/timer_bank_scheduler_unit_test.sv =====
// Testbench top of the timer bank scheduler: stimulus, idling, watchdog and verdict.
`timescale 1ns / 1ps
module timer_bank_scheduler_unit_test;
  import tbs_pkg::*;

  localparam int unsigned TIMERS       = 16;
  localparam int unsigned TOTAL_ITEMS  = 420;
  // Past this many commands both sides stop idling.
  localparam int unsigned CALM_AFTER   = 360;
  // Longest legal silence is a source gap, a scan with no fires and a sink stall;
  // allow many times that.
  localparam int unsigned IDLE_LIMIT   = 2000;
  // Wait well beyond a full scan and its drain.
  localparam int unsigned DRAIN_CYCLES = 3 * TIMERS + 16;

  // Codes outside the command set; the block must ignore them.
  localparam logic [CMD_W-1:0]   CMD_RSVD_FIRST = 3'd5;
  localparam logic [CMD_W-1:0]   CMD_RSVD_LAST  = 3'd7;
  localparam logic [DELAY_W-1:0] DELAY_MAX      = '1;
  localparam logic [DELAY_W-1:0] DELAY_ALT_A    = 31'h2AAA_AAAA;
  localparam logic [DELAY_W-1:0] DELAY_ALT_B    = 31'h5555_5555;
  localparam logic [ID_W-1:0]    ID_TOP         = '1;
  localparam logic               MD_SINGLE      = 1'b0;
  localparam logic               MD_REPEAT      = 1'b1;

  logic clk_i;
  logic rst_ni;

  tbs_req_if req_if ();
  tbs_rsp_if rsp_if ();

  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned fired_count;
  int unsigned reply_count;

  int unsigned useful_sent = 0;
  int unsigned op_seen [8];
  int unsigned idle_cycles = 0;
  bit          gaps_on     = 1'b1;
  bit          stalls_on   = 1'b1;

  timer_bank_scheduler_unit #(
    .TIMER_COUNT (TIMERS)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  timer_bank_scheduler_unit_checker #(
    .TIMERS (TIMERS)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_i            (req_if),
    .rsp_i            (rsp_if),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count),
    .fired_count_o    (fired_count),
    .reply_count_o    (reply_count)
  );

  // 12 ns clock.
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Send one command: change inputs on the falling edge, hold until the transfer.
  // Called on a falling edge and returns on the falling edge after the transfer,
  // so valid stays high between back-to-back commands.
  task automatic post_command(input logic [CMD_W-1:0] op, input logic [ID_W-1:0] id,
                              input logic md, input logic [DELAY_W-1:0] dly);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.cmd      <= op;
    req_if.timer_id <= id;
    req_if.mode     <= md;
    req_if.delay    <= dly;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    op_seen[op]++;
    if (op <= CMD_QUERY) useful_sent++;
    @(negedge clk_i);
  endtask

  // Mostly short delays so timers fire within the run; now and then any 31-bit value.
  function automatic logic [DELAY_W-1:0] pick_delay();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return DELAY_W'($urandom_range(0, 6));
    else if (r < 85) return DELAY_W'($urandom_range(7, 40));
    else if (r < 95) return DELAY_W'($urandom);
    else return DELAY_MAX;
  endfunction

  // Arm every timer with the same short delay: the next due scan fires the whole bank.
  task automatic arm_whole_bank(input logic [DELAY_W-1:0] dly);
    for (int i = 0; i < TIMERS; i++)
      post_command(CMD_START, ID_W'(i), 1'($urandom_range(0, 1)), dly);
  endtask

  // Sink side: stall in random bursts while stalls are enabled, otherwise accept.
  initial begin
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stalls_on && $urandom_range(0, 5) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk_i);
      end
      rsp_if.ready <= 1'b1;
    end
  end

  // Watchdog: end the run once nothing has moved on either channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles, %0d results still owed",
                 idle_cycles, pending_count);
        $display("timer_bank_scheduler_unit test failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned pick;
    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.cmd      = CMD_TICK;
    req_if.timer_id = '0;
    req_if.mode     = MD_SINGLE;
    req_if.delay    = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part: fresh state, both mode values, zero and maximum delay,
    // timeout then stop or re-arm, stop of an idle timer, ignored codes.
    post_command(CMD_QUERY, '0, MD_SINGLE, '0);
    post_command(CMD_QUERY, ID_TOP, MD_REPEAT, DELAY_MAX);
    post_command(CMD_START, '0, MD_SINGLE, '0);
    post_command(CMD_START, ID_TOP, MD_REPEAT, '0);
    post_command(CMD_START, 4'd5, MD_SINGLE, DELAY_MAX);
    post_command(CMD_START, 4'd10, MD_REPEAT, 31'd2);
    post_command(CMD_QUERY, '0, MD_SINGLE, '0);
    // fires timers 0 and 15, last on 15
    post_command(CMD_SCAN, '0, MD_SINGLE, '0);
    post_command(CMD_QUERY, '0, MD_SINGLE, '0);
    // timer 0 stops, timer 15 re-arms, nothing fires
    post_command(CMD_SCAN, ID_TOP, MD_REPEAT, DELAY_MAX);
    post_command(CMD_TICK, '0, MD_SINGLE, '0);
    post_command(CMD_TICK, ID_TOP, MD_REPEAT, DELAY_MAX);
    post_command(CMD_SCAN, '0, MD_SINGLE, '0);
    post_command(CMD_STOP, ID_TOP, MD_SINGLE, '0);
    post_command(CMD_QUERY, ID_TOP, MD_SINGLE, '0);
    post_command(CMD_STOP, 4'd7, MD_REPEAT, DELAY_MAX);
    for (int c = CMD_RSVD_FIRST; c <= CMD_RSVD_LAST; c++)
      post_command(CMD_W'(c), ID_W'($urandom), 1'($urandom), DELAY_W'($urandom));
    post_command(CMD_START, 4'd3, MD_REPEAT, DELAY_ALT_A);
    post_command(CMD_START, 4'd12, MD_SINGLE, DELAY_ALT_B);
    post_command(CMD_SCAN, '0, MD_SINGLE, '0);
    post_command(CMD_QUERY, 4'd5, MD_SINGLE, '0);
    post_command(CMD_QUERY, 4'd3, MD_SINGLE, '0);

    // Random part: ticks, scans and starts dominate so timers keep firing and
    // re-arming; queries sample state, stops cut timers short, a little noise.
    while (useful_sent < TOTAL_ITEMS) begin
      if (useful_sent >= CALM_AFTER) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end else if ($urandom_range(0, 31) == 0) begin
        // switch to a new window, some of them free of idling
        gaps_on   = ($urandom_range(0, 3) != 0);
        stalls_on = ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 30)
        post_command(CMD_TICK, ID_W'($urandom), 1'($urandom), DELAY_W'($urandom));
      else if (pick < 48)
        post_command(CMD_SCAN, ID_W'($urandom), 1'($urandom), DELAY_W'($urandom));
      else if (pick < 68)
        post_command(CMD_START, ID_W'($urandom), 1'($urandom), pick_delay());
      else if (pick < 76)
        post_command(CMD_STOP, ID_W'($urandom), 1'($urandom), DELAY_W'($urandom));
      else if (pick < 94)
        post_command(CMD_QUERY, ID_W'($urandom), 1'($urandom), DELAY_W'($urandom));
      else if (pick < 98)
        post_command(CMD_W'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST)), ID_W'($urandom),
                     1'($urandom), DELAY_W'($urandom));
      else begin
        // full bank can fire in one scan: sixteen events, last on the final one
        arm_whole_bank(DELAY_W'($urandom_range(0, 2)));
        repeat ($urandom_range(0, 2))
          post_command(CMD_TICK, ID_W'($urandom), 1'($urandom), DELAY_W'($urandom));
        post_command(CMD_SCAN, ID_W'($urandom), 1'($urandom), DELAY_W'($urandom));
      end
    end
    req_if.valid <= 1'b0;

    // Drain: wait for every owed result, then hold a while to catch strays.
    while (pending_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d commands: %0d ticks, %0d scans, %0d starts, %0d stops, %0d queries",
             op_seen.sum(), op_seen[CMD_TICK], op_seen[CMD_SCAN], op_seen[CMD_START],
             op_seen[CMD_STOP], op_seen[CMD_QUERY]);
    $display("Checked %0d fired events and %0d query replies, %0d mismatches",
             fired_count, reply_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("timer_bank_scheduler_unit test passed");
    end else begin
      $display("timer_bank_scheduler_unit test failed");
    end
    $finish;
  end

endmodule
